>>> src/markov_walk_probability_argmax_assert.svh
// Assertion macros for the markov walk block checker.
// Included by the checker file only; needs clk and rst_n in scope.
`ifndef MARKOV_WALK_PROBABILITY_ARGMAX_ASSERT_SVH
`define MARKOV_WALK_PROBABILITY_ARGMAX_ASSERT_SVH

// same-cycle implication
`define MWPA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MWPA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/mwpa_pkg.sv
// Shared constants and types for the markov walk argmax block.
// No dependencies; used by the interfaces, the top level, the checker and the testbench.
`default_nettype none

package mwpa_pkg;

  localparam int MAX_NODES  = 128;
  localparam int NODE_W     = 8;
  localparam int IDX_W      = $clog2(MAX_NODES);
  localparam int PROB_W     = 17;
  localparam int PROD_W     = 2 * PROB_W;
  localparam int STEP_W     = 7;
  localparam int EDGE_AW    = 2 * IDX_W;
  localparam int EDGE_W     = NODE_W + PROB_W;
  localparam int TIME_W     = 11;
  localparam int KIND_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;
  localparam int DIV_K_W    = 12;
  localparam int DIV_SH     = 15;
  localparam int DIV_PROD_W = TIME_W + DIV_K_W;

  localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ADD    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RUN    = 2'd2;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_TIME = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LEAD_TIME  = 2'd2;

  localparam logic [NODE_W-1:0]  NODE_LIMIT = NODE_W'(MAX_NODES);
  localparam logic [STEP_W-1:0]  STEP_CAP   = {STEP_W{1'b1}};
  localparam logic [PROB_W-1:0]  ONE_Q16    = 17'h10000;
  localparam logic [PROB_W-1:0]  PROB_MAX   = {PROB_W{1'b1}};
  localparam logic [DIV_K_W-1:0] DIV10_K    = 12'd3277;

  typedef enum logic [16:0] {
    S_IDLE      = 17'h00001,
    S_ADD       = 17'h00002,
    S_DIV_FIN   = 17'h00004,
    S_DIV_EARLY = 17'h00008,
    S_INIT      = 17'h00010,
    S_CHK       = 17'h00020,
    S_PICK_ADDR = 17'h00040,
    S_PICK_CMP  = 17'h00080,
    S_PROP      = 17'h00100,
    S_U_ADDR    = 17'h00200,
    S_U_DATA    = 17'h00400,
    S_E_ADDR    = 17'h00800,
    S_E_DATA    = 17'h01000,
    S_E_ACC     = 17'h02000,
    S_STEP_END  = 17'h04000,
    S_OUT_FIN   = 17'h08000,
    S_OUT_EARLY = 17'h10000
  } state_t;

endpackage

`default_nettype wire

>>> src/mwpa_if.sv
// Request and result channel interfaces of the markov walk block.
// Depends on mwpa_pkg for field widths.
`default_nettype none

interface mwpa_in_if;
  logic                          valid;
  logic                          ready;
  logic [mwpa_pkg::KIND_W-1:0]   kind;
  logic [mwpa_pkg::NODE_W-1:0]   src_node;
  logic [mwpa_pkg::NODE_W-1:0]   dst_node;
  logic [mwpa_pkg::PROB_W-1:0]   edge_weight;
  modport source (output valid, kind, src_node, dst_node, edge_weight, input ready);
  modport sink   (input valid, kind, src_node, dst_node, edge_weight, output ready);
endinterface

interface mwpa_out_if;
  logic                          valid;
  logic                          ready;
  logic                          which_query;
  logic [mwpa_pkg::NODE_W-1:0]   best_node;
  logic [mwpa_pkg::PROB_W-1:0]   best_probability;
  logic                          last;
  modport source (output valid, which_query, best_node, best_probability, last, input ready);
  modport sink   (input valid, which_query, best_node, best_probability, last, output ready);
endinterface

`default_nettype wire

>>> src/mwpa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module mwpa_ram #(
  parameter int W = 8,
  parameter int D = 128
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [$clog2(D)-1:0] wa,
  input  wire logic [W-1:0]         wd,
  input  wire logic [$clog2(D)-1:0] ra,
  output logic      [W-1:0]         rd
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd <= mem[ra];
  end

endmodule

`default_nettype wire

>>> src/markov_walk_probability_argmax.sv
// Markov walk argmax: edge store, step sequencer and result register.
// Depends on mwpa_pkg, mwpa_if and mwpa_ram.
//
// Usage: requests arrive on in_ch (valid/ready). kind 0 empties every
// adjacency list, kind 1 appends an edge if both ids are in 1..128 and
// the source list is not full, kind 2 runs the walk and returns two
// results on out_ch: the final-step argmax (last low) then the early-step
// argmax (last high); kind 3 is ignored. Registers are to be written
// through cfg_we/cfg_idx/cfg_data only while idle; the block itself does
// not enforce this. Each walk step visits every edge of each node in use
// with a nonzero probability: each such edge is a read, a multiply and a
// read-modify-write, and an edge to a node not in use is only read.
// in_ch.ready is low while a walk runs. The second result waits in the
// sequencer until the first is taken, and the block takes new requests
// once it is loaded into the output register. Reset is synchronous: lists
// empty, node_count 1, both times 0, no result pending. No clearing pass.
`default_nettype none

module markov_walk_probability_argmax (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [mwpa_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [mwpa_pkg::CFG_DATA_W-1:0] cfg_data,
  mwpa_in_if.sink                              in_ch,
  mwpa_out_if.source                           out_ch
);

  mwpa_pkg::state_t state_r, state_nxt;

  logic [mwpa_pkg::NODE_W-1:0]    node_count_r;
  logic [mwpa_pkg::TIME_W-1:0]    total_time_r, lead_time_r;
  logic [mwpa_pkg::NODE_W-1:0]    n_r;
  logic [mwpa_pkg::STEP_W-1:0]    fin_r, early_r, step_r;
  logic                           cur_r;
  logic [mwpa_pkg::MAX_NODES-1:0] vld0_r, vld1_r, ecnt_vld_r;
  logic [mwpa_pkg::IDX_W-1:0]     src_r, d_r;
  logic [mwpa_pkg::NODE_W-1:0]    dst_r;
  logic [mwpa_pkg::PROB_W-1:0]    wt_r, p_r, bp_r, fp_r, ep_r;
  logic [mwpa_pkg::NODE_W-1:0]    i_r, u_r, k_r, cnt_r, bi_r, fn_r, en_r;
  logic [mwpa_pkg::PROD_W-1:0]    prod_r;
  logic                           out_valid_r, out_wq_r, out_last_r;
  logic [mwpa_pkg::NODE_W-1:0]    out_node_r;
  logic [mwpa_pkg::PROB_W-1:0]    out_prob_r;

  logic                           in_fire, out_free, src_ok, dst_ok;
  logic [mwpa_pkg::NODE_W-1:0]    n_use, src_m1, dst_m1, e_dst, ecnt_data, ecnt_rd;
  logic [mwpa_pkg::NODE_W-1:0]    e_dst_m1;
  logic [mwpa_pkg::TIME_W-1:0]    diff, div_in;
  logic [mwpa_pkg::DIV_PROD_W-1:0] div_prod;
  logic [mwpa_pkg::NODE_W-1:0]    div_q;
  logic [mwpa_pkg::STEP_W-1:0]    div_step;
  logic [mwpa_pkg::IDX_W-1:0]     cur_addr, nxt_addr, ecnt_ra, ecnt_vidx;
  logic [mwpa_pkg::PROB_W-1:0]    rd0, rd1, cur_data, nxt_data, e_wt, sat;
  logic [mwpa_pkg::PROB_W+1:0]    sum;
  logic [mwpa_pkg::EDGE_W-1:0]    edge_rd;
  logic                           cur_vld, nxt_vld, add_ok, init_wr;
  logic                           we0, we1;
  logic [mwpa_pkg::IDX_W-1:0]     pwa;
  logic [mwpa_pkg::PROB_W-1:0]    pwd;

  assign in_ch.ready = (state_r == mwpa_pkg::S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  assign out_ch.valid            = out_valid_r;
  assign out_ch.which_query      = out_wq_r;
  assign out_ch.best_node        = out_node_r;
  assign out_ch.best_probability = out_prob_r;
  assign out_ch.last             = out_last_r;

  assign n_use  = (node_count_r > mwpa_pkg::NODE_LIMIT) ? mwpa_pkg::NODE_LIMIT : node_count_r;
  assign src_m1 = in_ch.src_node - 1'b1;
  assign dst_m1 = in_ch.dst_node - 1'b1;
  assign src_ok = (in_ch.src_node != '0) && (in_ch.src_node <= mwpa_pkg::NODE_LIMIT);
  assign dst_ok = (in_ch.dst_node != '0) && (in_ch.dst_node <= mwpa_pkg::NODE_LIMIT);

  // divide by ten: reciprocal multiply, exact over the 11-bit range
  assign diff     = (total_time_r >= lead_time_r) ? (total_time_r - lead_time_r) : '0;
  assign div_in   = (state_r == mwpa_pkg::S_DIV_FIN) ? total_time_r : diff;
  assign div_prod = mwpa_pkg::DIV_PROD_W'(div_in) * mwpa_pkg::DIV_PROD_W'(mwpa_pkg::DIV10_K);
  assign div_q    = div_prod[mwpa_pkg::DIV_SH +: mwpa_pkg::NODE_W];
  assign div_step = (div_q > mwpa_pkg::NODE_W'(mwpa_pkg::STEP_CAP)) ? mwpa_pkg::STEP_CAP
                                                                   : div_q[mwpa_pkg::STEP_W-1:0];

  // edge store
  assign e_dst    = edge_rd[mwpa_pkg::EDGE_W-1:mwpa_pkg::PROB_W];
  assign e_wt     = edge_rd[mwpa_pkg::PROB_W-1:0];
  assign ecnt_ra  = (state_r == mwpa_pkg::S_IDLE) ? src_m1[mwpa_pkg::IDX_W-1:0]
                                                  : u_r[mwpa_pkg::IDX_W-1:0];
  assign ecnt_vidx = (state_r == mwpa_pkg::S_ADD) ? src_r : u_r[mwpa_pkg::IDX_W-1:0];
  assign ecnt_data = ecnt_vld_r[ecnt_vidx] ? ecnt_rd : '0;
  assign add_ok    = (state_r == mwpa_pkg::S_ADD) && (ecnt_data < mwpa_pkg::NODE_LIMIT);

  mwpa_ram #(.W(mwpa_pkg::NODE_W), .D(mwpa_pkg::MAX_NODES)) u_ecnt (
    .clk (clk),
    .we  (add_ok),
    .wa  (src_r),
    .wd  (ecnt_data + 1'b1),
    .ra  (ecnt_ra),
    .rd  (ecnt_rd)
  );

  mwpa_ram #(.W(mwpa_pkg::EDGE_W), .D(mwpa_pkg::MAX_NODES * mwpa_pkg::MAX_NODES)) u_edge (
    .clk (clk),
    .we  (add_ok),
    .wa  ({src_r, ecnt_data[mwpa_pkg::IDX_W-1:0]}),
    .wd  ({dst_r, wt_r}),
    .ra  ({u_r[mwpa_pkg::IDX_W-1:0], k_r[mwpa_pkg::IDX_W-1:0]}),
    .rd  (edge_rd)
  );

  // probability banks, cur_r selects the current one
  assign cur_addr = (state_r == mwpa_pkg::S_PICK_ADDR || state_r == mwpa_pkg::S_PICK_CMP)
                  ? i_r[mwpa_pkg::IDX_W-1:0] : u_r[mwpa_pkg::IDX_W-1:0];
  assign e_dst_m1 = e_dst - 1'b1;
  assign nxt_addr = e_dst_m1[mwpa_pkg::IDX_W-1:0];
  assign cur_vld  = cur_r ? vld1_r[cur_addr] : vld0_r[cur_addr];
  assign cur_data = cur_vld ? (cur_r ? rd1 : rd0) : '0;
  assign nxt_vld  = cur_r ? vld0_r[d_r] : vld1_r[d_r];
  assign nxt_data = nxt_vld ? (cur_r ? rd0 : rd1) : '0;

  assign sum = (mwpa_pkg::PROB_W+2)'(prod_r[mwpa_pkg::PROD_W-1:16])
             + (mwpa_pkg::PROB_W+2)'(nxt_data);
  assign sat = (sum > (mwpa_pkg::PROB_W+2)'(mwpa_pkg::PROB_MAX)) ? mwpa_pkg::PROB_MAX
                                                                : sum[mwpa_pkg::PROB_W-1:0];

  assign init_wr = (state_r == mwpa_pkg::S_INIT) && (n_r != '0);
  assign we0 = (init_wr && !cur_r) || ((state_r == mwpa_pkg::S_E_ACC) && cur_r);
  assign we1 = (init_wr && cur_r)  || ((state_r == mwpa_pkg::S_E_ACC) && !cur_r);
  assign pwa = (state_r == mwpa_pkg::S_INIT) ? '0 : d_r;
  assign pwd = (state_r == mwpa_pkg::S_INIT) ? mwpa_pkg::ONE_Q16 : sat;

  mwpa_ram #(.W(mwpa_pkg::PROB_W), .D(mwpa_pkg::MAX_NODES)) u_prob0 (
    .clk (clk),
    .we  (we0),
    .wa  (pwa),
    .wd  (pwd),
    .ra  (cur_r ? nxt_addr : cur_addr),
    .rd  (rd0)
  );

  mwpa_ram #(.W(mwpa_pkg::PROB_W), .D(mwpa_pkg::MAX_NODES)) u_prob1 (
    .clk (clk),
    .we  (we1),
    .wa  (pwa),
    .wd  (pwd),
    .ra  (cur_r ? cur_addr : nxt_addr),
    .rd  (rd1)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mwpa_pkg::S_IDLE: begin
        if (in_fire) begin
          unique case (in_ch.kind)
            mwpa_pkg::KIND_ADD: if (src_ok && dst_ok) state_nxt = mwpa_pkg::S_ADD;
            mwpa_pkg::KIND_RUN: state_nxt = mwpa_pkg::S_DIV_FIN;
            default:            state_nxt = mwpa_pkg::S_IDLE;
          endcase
        end
      end
      mwpa_pkg::S_ADD:       state_nxt = mwpa_pkg::S_IDLE;
      mwpa_pkg::S_DIV_FIN:   state_nxt = mwpa_pkg::S_DIV_EARLY;
      mwpa_pkg::S_DIV_EARLY: state_nxt = mwpa_pkg::S_INIT;
      mwpa_pkg::S_INIT:      state_nxt = mwpa_pkg::S_CHK;
      mwpa_pkg::S_CHK:       state_nxt = mwpa_pkg::S_PICK_ADDR;
      mwpa_pkg::S_PICK_ADDR: begin
        if (i_r == n_r) begin
          state_nxt = (step_r >= fin_r) ? mwpa_pkg::S_OUT_FIN : mwpa_pkg::S_PROP;
        end else begin
          state_nxt = mwpa_pkg::S_PICK_CMP;
        end
      end
      mwpa_pkg::S_PICK_CMP:  state_nxt = mwpa_pkg::S_PICK_ADDR;
      mwpa_pkg::S_PROP:      state_nxt = mwpa_pkg::S_U_ADDR;
      mwpa_pkg::S_U_ADDR: begin
        state_nxt = (u_r == n_r) ? mwpa_pkg::S_STEP_END : mwpa_pkg::S_U_DATA;
      end
      mwpa_pkg::S_U_DATA: begin
        state_nxt = (cur_data == '0 || ecnt_data == '0) ? mwpa_pkg::S_U_ADDR
                                                        : mwpa_pkg::S_E_ADDR;
      end
      mwpa_pkg::S_E_ADDR: begin
        state_nxt = (k_r == cnt_r) ? mwpa_pkg::S_U_ADDR : mwpa_pkg::S_E_DATA;
      end
      mwpa_pkg::S_E_DATA: begin
        state_nxt = (e_dst == '0 || e_dst > n_r) ? mwpa_pkg::S_E_ADDR : mwpa_pkg::S_E_ACC;
      end
      mwpa_pkg::S_E_ACC:     state_nxt = mwpa_pkg::S_E_ADDR;
      mwpa_pkg::S_STEP_END:  state_nxt = mwpa_pkg::S_CHK;
      mwpa_pkg::S_OUT_FIN:   if (out_free) state_nxt = mwpa_pkg::S_OUT_EARLY;
      mwpa_pkg::S_OUT_EARLY: if (out_free) state_nxt = mwpa_pkg::S_IDLE;
      default:               state_nxt = mwpa_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= mwpa_pkg::S_IDLE;
      node_count_r <= mwpa_pkg::NODE_W'(1);
      total_time_r <= '0;
      lead_time_r  <= '0;
      ecnt_vld_r   <= '0;
      vld0_r       <= '0;
      vld1_r       <= '0;
      cur_r        <= 1'b0;
      step_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_we) begin
        unique case (cfg_idx)
          mwpa_pkg::CFG_NODE_COUNT: node_count_r <= cfg_data[mwpa_pkg::NODE_W-1:0];
          mwpa_pkg::CFG_TOTAL_TIME: total_time_r <= cfg_data[mwpa_pkg::TIME_W-1:0];
          mwpa_pkg::CFG_LEAD_TIME:  lead_time_r  <= cfg_data[mwpa_pkg::TIME_W-1:0];
          default: ;
        endcase
      end

      if (in_fire && in_ch.kind == mwpa_pkg::KIND_CLEAR) begin
        ecnt_vld_r <= '0;
      end
      if (add_ok) begin
        ecnt_vld_r[src_r] <= 1'b1;
      end

      if (state_r == mwpa_pkg::S_INIT) begin
        if (!cur_r) vld0_r <= mwpa_pkg::MAX_NODES'(n_r != '0);
        else        vld1_r <= mwpa_pkg::MAX_NODES'(n_r != '0);
        step_r <= '0;
      end
      if (state_r == mwpa_pkg::S_PROP) begin
        if (cur_r) vld0_r <= '0;
        else       vld1_r <= '0;
      end
      if (state_r == mwpa_pkg::S_E_ACC) begin
        if (cur_r) vld0_r[d_r] <= 1'b1;
        else       vld1_r[d_r] <= 1'b1;
      end
      if (state_r == mwpa_pkg::S_STEP_END) begin
        cur_r  <= !cur_r;
        step_r <= step_r + 1'b1;
      end

      if ((state_r == mwpa_pkg::S_OUT_FIN || state_r == mwpa_pkg::S_OUT_EARLY) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers, no reset
  always_ff @(posedge clk) begin
    case (state_r)
      mwpa_pkg::S_IDLE: begin
        src_r <= src_m1[mwpa_pkg::IDX_W-1:0];
        dst_r <= in_ch.dst_node;
        wt_r  <= in_ch.edge_weight;
        n_r   <= n_use;
        if (dst_m1 == '0) d_r <= '0;
      end
      mwpa_pkg::S_DIV_FIN:   fin_r   <= div_step;
      mwpa_pkg::S_DIV_EARLY: early_r <= div_step;
      mwpa_pkg::S_CHK: begin
        i_r  <= '0;
        bi_r <= '0;
        bp_r <= '0;
      end
      mwpa_pkg::S_PICK_ADDR: begin
        if (i_r == n_r) begin
          if (step_r == early_r) begin
            en_r <= bi_r;
            ep_r <= bp_r;
          end
          if (step_r >= fin_r) begin
            fn_r <= bi_r;
            fp_r <= bp_r;
          end
        end
      end
      mwpa_pkg::S_PICK_CMP: begin
        if (cur_data > bp_r) begin
          bp_r <= cur_data;
          bi_r <= i_r + 1'b1;
        end
        i_r <= i_r + 1'b1;
      end
      mwpa_pkg::S_PROP: u_r <= '0;
      mwpa_pkg::S_U_DATA: begin
        if (cur_data == '0 || ecnt_data == '0) begin
          u_r <= u_r + 1'b1;
        end else begin
          p_r   <= cur_data;
          cnt_r <= ecnt_data;
          k_r   <= '0;
        end
      end
      mwpa_pkg::S_E_ADDR: if (k_r == cnt_r) u_r <= u_r + 1'b1;
      mwpa_pkg::S_E_DATA: begin
        if (e_dst == '0 || e_dst > n_r) begin
          k_r <= k_r + 1'b1;
        end else begin
          d_r    <= nxt_addr;
          prod_r <= mwpa_pkg::PROD_W'(p_r) * mwpa_pkg::PROD_W'(e_wt);
        end
      end
      mwpa_pkg::S_E_ACC: k_r <= k_r + 1'b1;
      mwpa_pkg::S_OUT_FIN: begin
        if (out_free) begin
          out_wq_r   <= 1'b0;
          out_node_r <= fn_r;
          out_prob_r <= fp_r;
          out_last_r <= 1'b0;
        end
      end
      mwpa_pkg::S_OUT_EARLY: begin
        if (out_free) begin
          out_wq_r   <= 1'b1;
          out_node_r <= en_r;
          out_prob_r <= ep_r;
          out_last_r <= 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

>>> src/mwpa_checker.sv
// Port-level checker for the markov walk block, bound to the top level.
// Depends on mwpa_pkg and markov_walk_probability_argmax_assert.svh.
`default_nettype none

`include "markov_walk_probability_argmax_assert.svh"

module mwpa_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_ready,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic                          which_query,
  input wire logic [mwpa_pkg::NODE_W-1:0]   best_node,
  input wire logic [mwpa_pkg::PROB_W-1:0]   best_probability,
  input wire logic                          last
);

  `MWPA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(best_node) && $stable(best_probability) && $stable(last), "result changed while stalled")
  `MWPA_ASSERT_NOW(a_query_tag, out_valid, which_query == last, "query tag does not match last flag")
  `MWPA_ASSERT_NOW(a_no_req_mid, out_valid && !last, !in_ready, "request taken between the two results")
  `MWPA_ASSERT_NEXT(a_pair, out_valid && !last && out_ready, out_valid && last, "second result did not follow")
  `MWPA_ASSERT_NOW(a_zero_node, out_valid && best_node == '0, best_probability == '0, "node zero with nonzero probability")

endmodule

bind markov_walk_probability_argmax mwpa_checker u_mwpa_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .which_query      (out_ch.which_query),
  .best_node        (out_ch.best_node),
  .best_probability (out_ch.best_probability),
  .last             (out_ch.last)
);

`default_nettype wire

>>> tb/markov_walk_probability_argmax_tb.sv
// Testbench for markov_walk_probability_argmax: random and directed requests,
// a built-in predictor of the walk and an in-order result check.
// Depends on mwpa_pkg and the mwpa_in_if / mwpa_out_if interfaces.
`timescale 1ns / 1ps

module markov_walk_probability_argmax_tb;

  typedef struct {
    logic [mwpa_pkg::KIND_W-1:0] kind;
    logic [mwpa_pkg::NODE_W-1:0] src;
    logic [mwpa_pkg::NODE_W-1:0] dst;
    logic [mwpa_pkg::PROB_W-1:0] wt;
  } walk_req_t;

  typedef struct {
    logic                        which;
    logic [mwpa_pkg::NODE_W-1:0] node;
    logic [mwpa_pkg::PROB_W-1:0] prob;
    logic                        last;
  } argmax_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [mwpa_pkg::CFG_IDX_W-1:0] cfg_idx;
  logic [mwpa_pkg::CFG_DATA_W-1:0] cfg_data;

  mwpa_in_if  in_ch ();
  mwpa_out_if out_ch ();

  markov_walk_probability_argmax i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_we  (cfg_we),
    .cfg_idx (cfg_idx),
    .cfg_data(cfg_data),
    .in_ch   (in_ch),
    .out_ch  (out_ch)
  );

  walk_req_t req_q[$];
  argmax_t   argmax_q[$];
  int send_idle_pct;
  int recv_stall_pct;
  int n_errors;
  int n_results;
  int n_walks;

  // predictor state
  int nodes_cfg;
  int total_cfg;
  int lead_cfg;
  int list_len[mwpa_pkg::MAX_NODES];
  int list_dst[mwpa_pkg::MAX_NODES*mwpa_pkg::MAX_NODES];
  int list_wt[mwpa_pkg::MAX_NODES*mwpa_pkg::MAX_NODES];
  int prob_cur[mwpa_pkg::MAX_NODES];

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic void push_req(int k, int s, int d, int w);
    walk_req_t r;
    r.kind = k[mwpa_pkg::KIND_W-1:0];
    r.src  = s[mwpa_pkg::NODE_W-1:0];
    r.dst  = d[mwpa_pkg::NODE_W-1:0];
    r.wt   = w[mwpa_pkg::PROB_W-1:0];
    req_q.push_back(r);
  endfunction

  function automatic void pick_argmax(int n, output int bn, output int bp);
    bn = 0;
    bp = 0;
    for (int i = 0; i < n; i++) begin
      if (prob_cur[i] > bp) begin
        bp = prob_cur[i];
        bn = i + 1;
      end
    end
  endfunction

  function automatic void predict_walk();
    int n, fin, early, fn, fp, en, ep, d, c, cnt, cap;
    int nxt[mwpa_pkg::MAX_NODES];
    argmax_t a;
    cap = int'(mwpa_pkg::STEP_CAP);
    n = (nodes_cfg > mwpa_pkg::MAX_NODES) ? mwpa_pkg::MAX_NODES : nodes_cfg;
    fin = total_cfg / 10;
    if (fin > cap) fin = cap;
    early = (total_cfg >= lead_cfg) ? (total_cfg - lead_cfg) / 10 : 0;
    if (early > cap) early = cap;
    fn = 0; fp = 0; en = 0; ep = 0;
    foreach (prob_cur[i]) prob_cur[i] = 0;
    if (n >= 1) prob_cur[0] = mwpa_pkg::ONE_Q16;
    for (int st = 0; ; st++) begin
      if (st == early) pick_argmax(n, en, ep);
      if (st >= fin) begin
        pick_argmax(n, fn, fp);
        break;
      end
      foreach (nxt[i]) nxt[i] = 0;
      for (int u = 0; u < n; u++) begin
        if (prob_cur[u] == 0) continue;
        cnt = list_len[u];
        for (int k = 0; k < cnt; k++) begin
          d = list_dst[u*mwpa_pkg::MAX_NODES+k];
          if (d == 0 || d > n) continue;
          c = int'((longint'(prob_cur[u]) * list_wt[u*mwpa_pkg::MAX_NODES+k]) >>> 16)
            + nxt[d-1];
          nxt[d-1] = (c > mwpa_pkg::PROB_MAX) ? mwpa_pkg::PROB_MAX : c;
        end
      end
      prob_cur = nxt;
    end
    a.which = 1'b0; a.node = fn[mwpa_pkg::NODE_W-1:0]; a.prob = fp[mwpa_pkg::PROB_W-1:0];
    a.last = 1'b0;
    argmax_q.push_back(a);
    a.which = 1'b1; a.node = en[mwpa_pkg::NODE_W-1:0]; a.prob = ep[mwpa_pkg::PROB_W-1:0];
    a.last = 1'b1;
    argmax_q.push_back(a);
    n_walks++;
  endfunction

  function automatic void apply_req(walk_req_t r);
    int s, d, base;
    s = r.src;
    d = r.dst;
    case (r.kind)
      mwpa_pkg::KIND_CLEAR: foreach (list_len[i]) list_len[i] = 0;
      mwpa_pkg::KIND_ADD: begin
        if (s >= 1 && s <= mwpa_pkg::MAX_NODES && d >= 1 && d <= mwpa_pkg::MAX_NODES &&
            list_len[s-1] < mwpa_pkg::MAX_NODES) begin
          base = (s-1)*mwpa_pkg::MAX_NODES + list_len[s-1];
          list_dst[base] = d;
          list_wt[base]  = r.wt;
          list_len[s-1]++;
        end
      end
      mwpa_pkg::KIND_RUN: predict_walk();
      default: ;
    endcase
  endfunction

  // request driver
  always @(posedge clk) begin
    walk_req_t r;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        r.kind = in_ch.kind; r.src = in_ch.src_node;
        r.dst = in_ch.dst_node; r.wt = in_ch.edge_weight;
        apply_req(r);
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (req_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          r = req_q.pop_front();
          in_ch.valid       <= 1'b1;
          in_ch.kind        <= r.kind;
          in_ch.src_node    <= r.src;
          in_ch.dst_node    <= r.dst;
          in_ch.edge_weight <= r.wt;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    argmax_t e;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        n_results++;
        if (argmax_q.size() == 0) begin
          n_errors++;
          if (n_errors <= 10)
            $display("ERROR: unexpected result node=%0d prob=%0d", out_ch.best_node,
                     out_ch.best_probability);
        end else begin
          e = argmax_q.pop_front();
          if (out_ch.which_query !== e.which || out_ch.best_node !== e.node ||
              out_ch.best_probability !== e.prob || out_ch.last !== e.last) begin
            n_errors++;
            if (n_errors <= 10)
              $display("ERROR: exp q=%0d node=%0d prob=%0d last=%0d, %s%0d %s%0d %s%0d %s%0d",
                       e.which, e.node, e.prob, e.last, "got q=", out_ch.which_query,
                       "node=", out_ch.best_node, "prob=", out_ch.best_probability,
                       "last=", out_ch.last);
          end
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic wait_quiet();
    do @(negedge clk); while (req_q.size() != 0 || in_ch.valid || argmax_q.size() != 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [mwpa_pkg::CFG_IDX_W-1:0] idx, int val);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val[mwpa_pkg::CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_we   <= 1'b0;
    case (idx)
      mwpa_pkg::CFG_NODE_COUNT: nodes_cfg = val & 8'hFF;
      mwpa_pkg::CFG_TOTAL_TIME: total_cfg = val & 11'h7FF;
      default:                  lead_cfg  = val & 11'h7FF;
    endcase
  endtask

  task automatic set_regs(int n, int t, int l);
    write_reg(mwpa_pkg::CFG_NODE_COUNT, n);
    write_reg(mwpa_pkg::CFG_TOTAL_TIME, t);
    write_reg(mwpa_pkg::CFG_LEAD_TIME, l);
  endtask

  function automatic int rand_weight();
    case ($urandom_range(9))
      0: return 0;
      1: return mwpa_pkg::ONE_Q16;
      2: return $urandom_range(131071);
      default: return $urandom_range(65536);
    endcase
  endfunction

  function automatic void rand_phase(int n, int n_items, bit full_list);
    int nn;
    nn = (n < 1) ? 1 : (n > mwpa_pkg::MAX_NODES ? mwpa_pkg::MAX_NODES : n);
    push_req(mwpa_pkg::KIND_CLEAR, $urandom_range(255), $urandom_range(255),
             $urandom_range(131071));
    if (full_list)
      for (int i = 0; i < mwpa_pkg::MAX_NODES + 3; i++)
        push_req(mwpa_pkg::KIND_ADD, 1, $urandom_range(1, nn), rand_weight());
    for (int i = 0; i < n_items; i++) begin
      case ($urandom_range(19))
        0: push_req(mwpa_pkg::KIND_RUN, $urandom_range(255), $urandom_range(255),
                    $urandom_range(131071));
        1: push_req(mwpa_pkg::KIND_ADD, $urandom_range(255), $urandom_range(255),
                    rand_weight());
        2: push_req(mwpa_pkg::KIND_UNUSED, $urandom_range(255), $urandom_range(255),
                    $urandom_range(131071));
        3: push_req(mwpa_pkg::KIND_ADD, $urandom_range(1, nn + 2 > 128 ? 128 : nn + 2),
                    $urandom_range(1, 128), rand_weight());
        default: push_req(mwpa_pkg::KIND_ADD, $urandom_range(1, nn), $urandom_range(1, nn),
                          rand_weight());
      endcase
    end
    push_req(mwpa_pkg::KIND_RUN, 0, 0, 0);
  endfunction

  initial begin
    int n, t;
    rst_n = 1'b0;
    cfg_we = 1'b0; cfg_idx = '0; cfg_data = '0;
    in_ch.valid = 1'b0; in_ch.kind = '0; in_ch.src_node = '0;
    in_ch.dst_node = '0; in_ch.edge_weight = '0;
    out_ch.ready = 1'b0;
    send_idle_pct = 0; recv_stall_pct = 0;
    n_errors = 0; n_results = 0; n_walks = 0;
    nodes_cfg = 1; total_cfg = 0; lead_cfg = 0;
    foreach (list_len[i]) list_len[i] = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset values, saturation, ties, bad ids, unused kind
    push_req(mwpa_pkg::KIND_RUN, 0, 0, 0);
    wait_quiet();
    set_regs(4, 35, 12);
    push_req(mwpa_pkg::KIND_ADD, 1, 2, 32768);
    push_req(mwpa_pkg::KIND_ADD, 1, 3, 32768);
    push_req(mwpa_pkg::KIND_ADD, 2, 4, 131071);
    push_req(mwpa_pkg::KIND_ADD, 3, 4, 131071);
    push_req(mwpa_pkg::KIND_ADD, 4, 4, 131071);
    push_req(mwpa_pkg::KIND_ADD, 0, 2, 65536);
    push_req(mwpa_pkg::KIND_ADD, 1, 200, 65536);
    push_req(mwpa_pkg::KIND_ADD, 255, 1, 65536);
    push_req(mwpa_pkg::KIND_ADD, 4, 5, 65536);
    push_req(mwpa_pkg::KIND_UNUSED, 255, 255, 131071);
    push_req(mwpa_pkg::KIND_RUN, 0, 0, 0);
    wait_quiet();
    set_regs(0, 1279, 0);
    push_req(mwpa_pkg::KIND_RUN, 0, 0, 0);
    wait_quiet();
    set_regs(255, 20, 1279);
    push_req(mwpa_pkg::KIND_RUN, 0, 0, 0);
    push_req(mwpa_pkg::KIND_CLEAR, 0, 0, 0);
    push_req(mwpa_pkg::KIND_RUN, 0, 0, 0);

    // random phases cycling through the idling modes
    for (int ph = 0; ph < 28; ph++) begin
      wait_quiet();
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
        default: begin send_idle_pct = 21; recv_stall_pct = 21; end
      endcase
      case ($urandom_range(9))
        0: n = 128;
        1: n = $urandom_range(129, 255);
        2: n = 0;
        default: n = $urandom_range(1, 16);
      endcase
      t = ($urandom_range(7) == 0) ? 1279 : $urandom_range(300);
      if (ph == 5) t = $urandom_range(60);
      set_regs(n, t, $urandom_range(3) == 0 ? $urandom_range(1279) : $urandom_range(t));
      rand_phase(n, 55, ph == 5);
    end

    wait_quiet();
    repeat (50) @(posedge clk);
    $display("Summary: %0d walks and %0d results checked over 28 random phases,", n_walks,
             n_results);
    $display("  with sender gaps, receiver stalls, saturation, full lists and bad ids.");
    if (n_errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #250ms;
    $display("Timeout");
    $display("Verification failed");
    $finish;
  end

endmodule

>>> markov_walk_probability_argmax.f
+incdir+src
src/mwpa_pkg.sv
src/mwpa_if.sv
src/mwpa_ram.sv
src/markov_walk_probability_argmax.sv
src/mwpa_checker.sv
tb/markov_walk_probability_argmax_tb.sv
